>>> rtl/lsp_pkg.sv
// Shared types and constants for the localization string table parser.
package lsp_pkg;

   localparam logic [31:0] LocMagic = 32'h0E14DAD9;
   localparam logic [30:0] MaxCharsReset = 31'h0010_0000;

   localparam logic [2:0] KIND_TEXT   = 3'd0;
   localparam logic [2:0] KIND_NULRUN = 3'd1;
   localparam logic [2:0] KIND_STREND = 3'd2;
   localparam logic [2:0] KIND_VER    = 3'd3;
   localparam logic [2:0] KIND_BADMAG = 3'd4;
   localparam logic [2:0] KIND_DONE   = 3'd5;
   localparam logic [2:0] KIND_TRUNC  = 3'd6;

   localparam logic [1:0] ROLE_NAME  = 2'd0;
   localparam logic [1:0] ROLE_KEY   = 2'd1;
   localparam logic [1:0] ROLE_VALUE = 2'd2;

   localparam int unsigned MaxRes = 5;
   localparam int unsigned QueueDepth = 2;

   // One result item.
   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  role;
      logic [7:0]  value;
      logic [30:0] run;
      logic        empty;
      logic        last;
   } result_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [2:0]  count;
      result_type [MaxRes-1:0] res;
   } batch_type;

   function automatic result_type mk_res(input logic [2:0] k, input logic [1:0] r,
                                         input logic [7:0] v, input logic [30:0] n,
                                         input logic e);
      result_type t;
      t.kind = k;
      t.role = r;
      t.value = v;
      t.run = n;
      t.empty = e;
      t.last = 1'b0;
      return t;
   endfunction

endpackage

>>> rtl/locres_string_table_parser.sv
// Top level of the localization string table parser.
// A byte's batch is registered in the front end, then in the queue, before output.
// Throughput, while rsp_ready is high: one byte per cycle while each byte gives at
// most one result; the output stage sends one result per cycle.
// Reset is synchronous and active high; max_chars returns to 1048576.
module locres_string_table_parser
   import lsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_max_chars,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_string_role,
   output logic [7:0]  rsp_byte_value,
   output logic [30:0] rsp_run_length,
   output logic        rsp_string_empty,
   output logic        rsp_last_result
);

   // The front end registers each byte's batch; the queue lets it keep taking
   // bytes while the back end sends earlier results one transfer at a time.
   logic       f_valid, f_ready, q_valid, q_ready;
   batch_type  f_data, q_data;
   result_type r;

   lsp_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_max_chars,
      .in_valid(req_valid), .in_ready(req_ready), .in_byte(req_data_byte),
      .in_eof(req_end_of_file),
      .b_valid(f_valid), .b_ready(f_ready), .b_data(f_data)
   );

   lsp_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   lsp_back u_back (
      .clock, .reset,
      .b_valid(q_valid), .b_ready(q_ready), .b_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(r)
   );

   assign rsp_kind         = r.kind;
   assign rsp_string_role  = r.role;
   assign rsp_byte_value   = r.value;
   assign rsp_run_length   = r.run;
   assign rsp_string_empty = r.empty;
   assign rsp_last_result  = r.last;

endmodule

>>> rtl/lsp_front.sv
// Front end: runs the parse state machine and turns each byte into a batch of results.
module lsp_front
   import lsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_max_chars,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_eof,
   output logic        b_valid,
   input  logic        b_ready,
   output batch_type   b_data
);

   localparam logic [3:0] PH_MAGIC = 4'd0;
   localparam logic [3:0] PH_VERSION = 4'd1;
   localparam logic [3:0] PH_OFFSET = 4'd2;
   localparam logic [3:0] PH_NSCOUNT = 4'd3;
   localparam logic [3:0] PH_STRLEN = 4'd4;
   localparam logic [3:0] PH_CHARS = 4'd5;
   localparam logic [3:0] PH_KEYCOUNT = 4'd6;
   localparam logic [3:0] PH_HASH = 4'd7;
   localparam logic [3:0] PH_IDLE = 4'd8;

   logic [30:0] maxc_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] ns_ff, ns_in, keys_ff, keys_in, chars_ff, chars_in;
   logic        wide_ff, wide_in, stop_ff, stop_in, any_ff, any_in;
   logic [7:0]  low_ff, low_in;
   logic [30:0] nuls_ff, nuls_in;
   logic [1:0]  role_ff, role_in;
   logic        bv_ff;
   batch_type   bd_ff, bd_in;

   assign csr_ready = 1'b1;
   assign in_ready  = !bv_ff || b_ready;
   assign b_valid   = bv_ff;
   assign b_data    = bd_ff;

   always_comb begin
      logic [31:0] w, mag, cu;
      logic        done4, endstr, finns;
      logic [2:0]  n;
      phase_in = phase_ff; idx_in = idx_ff; acc_in = acc_ff;
      ns_in = ns_ff; keys_in = keys_ff; chars_in = chars_ff;
      wide_in = wide_ff; stop_in = stop_ff; any_in = any_ff;
      low_in = low_ff; nuls_in = nuls_ff; role_in = role_ff;
      bd_in = '0;
      n = 3'd0;
      endstr = 1'b0;
      finns = 1'b0;
      mag = '0;
      cu = {16'd0, in_byte, low_ff};
      w = acc_ff;
      case (idx_ff[1:0])
         2'd0: w[7:0] = in_byte;
         2'd1: w[15:8] = in_byte;
         2'd2: w[23:16] = in_byte;
         default: w[31:24] = in_byte;
      endcase
      if (idx_ff >= 3'd4) w = acc_ff;
      done4 = (idx_ff == 3'd3);
      // Field collection for four-byte fields.
      if (!done4) begin
         acc_in = w;
         idx_in = idx_ff + 3'd1;
      end
      case (phase_ff)
         PH_MAGIC: begin
            if (done4) begin
               if (w == LocMagic) begin
                  phase_in = PH_VERSION; idx_in = '0; acc_in = '0;
               end else begin
                  bd_in.res[n] = mk_res(KIND_BADMAG, ROLE_NAME, 8'd0, 31'd0, 1'b0);
                  n = n + 3'd1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_VERSION: begin
            bd_in.res[n] = mk_res(KIND_VER, ROLE_NAME, in_byte, 31'd0, 1'b0);
            n = n + 3'd1;
            phase_in = PH_OFFSET; idx_in = '0; acc_in = '0;
         end
         PH_OFFSET: begin
            acc_in = w;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               phase_in = PH_NSCOUNT; idx_in = '0; acc_in = '0;
            end
         end
         PH_NSCOUNT: begin
            if (done4) begin
               ns_in = w;
               if (w == '0) begin
                  bd_in.res[n] = mk_res(KIND_DONE, ROLE_NAME, 8'd0, 31'd0, 1'b0);
                  n = n + 3'd1;
                  phase_in = PH_IDLE;
               end else begin
                  role_in = ROLE_NAME; phase_in = PH_STRLEN; idx_in = '0; acc_in = '0;
               end
            end
         end
         PH_STRLEN: begin
            if (done4) begin
               mag = w[31] ? (32'd0 - w) : w;
               any_in = 1'b0; nuls_in = '0; stop_in = 1'b0; wide_in = w[31];
               if (mag == '0 || mag > {1'b0, maxc_ff}) begin
                  endstr = 1'b1;
               end else begin
                  chars_in = mag; idx_in = '0; phase_in = PH_CHARS;
               end
            end
         end
         PH_CHARS: begin
            idx_in = idx_ff;
            acc_in = acc_ff;
            if (!wide_ff) begin
               if (in_byte == 8'd0) begin
                  nuls_in = nuls_ff + 31'd1;
               end else begin
                  if (nuls_ff != '0) begin
                     bd_in.res[n] = mk_res(KIND_NULRUN, role_ff, 8'd0, nuls_ff, 1'b0);
                     n = n + 3'd1;
                     nuls_in = '0;
                  end
                  bd_in.res[n] = mk_res(KIND_TEXT, role_ff, in_byte, 31'd0, 1'b0);
                  n = n + 3'd1;
                  any_in = 1'b1;
               end
               chars_in = chars_ff - 32'd1;
               endstr = (chars_in == '0);
            end else if (!idx_ff[0]) begin
               low_in = in_byte;
               idx_in = 3'd1;
            end else begin
               idx_in = '0;
               if (!stop_ff) begin
                  if (cu == '0) begin
                     stop_in = 1'b1;
                  end else if (cu < 32'h80) begin
                     bd_in.res[n] = mk_res(KIND_TEXT, role_ff, cu[7:0], 31'd0, 1'b0);
                     n = n + 3'd1;
                     any_in = 1'b1;
                  end else if (cu < 32'h800) begin
                     bd_in.res[n] = mk_res(KIND_TEXT, role_ff, {3'b110, cu[10:6]},
                                           31'd0, 1'b0);
                     bd_in.res[n+3'd1] = mk_res(KIND_TEXT, role_ff, {2'b10, cu[5:0]},
                                                31'd0, 1'b0);
                     n = n + 3'd2;
                     any_in = 1'b1;
                  end else begin
                     bd_in.res[n] = mk_res(KIND_TEXT, role_ff, {4'b1110, cu[15:12]},
                                           31'd0, 1'b0);
                     bd_in.res[n+3'd1] = mk_res(KIND_TEXT, role_ff, {2'b10, cu[11:6]},
                                                31'd0, 1'b0);
                     bd_in.res[n+3'd2] = mk_res(KIND_TEXT, role_ff, {2'b10, cu[5:0]},
                                                31'd0, 1'b0);
                     n = n + 3'd3;
                     any_in = 1'b1;
                  end
               end
               chars_in = chars_ff - 32'd1;
               endstr = (chars_in == '0);
            end
         end
         PH_KEYCOUNT: begin
            if (done4) begin
               keys_in = w;
               if (w == '0) begin
                  finns = 1'b1;
               end else begin
                  role_in = ROLE_KEY; phase_in = PH_STRLEN; idx_in = '0; acc_in = '0;
               end
            end
         end
         PH_HASH: begin
            if (done4) begin
               role_in = ROLE_VALUE; phase_in = PH_STRLEN; idx_in = '0; acc_in = '0;
            end
         end
         default: begin
            idx_in = idx_ff;
            acc_in = acc_ff;
         end
      endcase
      if (endstr) begin
         bd_in.res[n] = mk_res(KIND_STREND, role_ff, 8'd0, 31'd0, !any_in);
         n = n + 3'd1;
         any_in = 1'b0; nuls_in = '0; chars_in = '0;
         idx_in = '0; acc_in = '0;
         if (role_ff == ROLE_NAME) begin
            phase_in = PH_KEYCOUNT;
         end else if (role_ff == ROLE_KEY) begin
            phase_in = PH_HASH;
         end else begin
            keys_in = keys_ff - 32'd1;
            if (keys_in == '0) begin
               finns = 1'b1;
            end else begin
               role_in = ROLE_KEY; phase_in = PH_STRLEN;
            end
         end
      end
      if (finns) begin
         ns_in = ns_ff - 32'd1;
         if (ns_in == '0) begin
            bd_in.res[n] = mk_res(KIND_DONE, ROLE_NAME, 8'd0, 31'd0, 1'b0);
            n = n + 3'd1;
            phase_in = PH_IDLE;
         end else begin
            role_in = ROLE_NAME; phase_in = PH_STRLEN; idx_in = '0; acc_in = '0;
         end
      end
      if (in_eof) begin
         if (phase_in != PH_IDLE) begin
            bd_in.res[n] = mk_res(KIND_TRUNC, ROLE_NAME, 8'd0, 31'd0, 1'b0);
            n = n + 3'd1;
         end
         phase_in = PH_MAGIC; idx_in = '0; acc_in = '0; ns_in = '0; keys_in = '0;
         chars_in = '0; wide_in = 1'b0; low_in = '0; stop_in = 1'b0; nuls_in = '0;
         any_in = 1'b0; role_in = ROLE_NAME;
      end
      if (n != 3'd0) begin
         bd_in.res[n-3'd1].last = 1'b1;
      end
      bd_in.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxc_ff <= MaxCharsReset;
         phase_ff <= PH_MAGIC; idx_ff <= '0; acc_ff <= '0; ns_ff <= '0;
         keys_ff <= '0; chars_ff <= '0; wide_ff <= 1'b0; low_ff <= '0;
         stop_ff <= 1'b0; nuls_ff <= '0; any_ff <= 1'b0; role_ff <= ROLE_NAME;
         bv_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            maxc_ff <= csr_max_chars;
         end
         if (in_ready) begin
            bv_ff <= in_valid && (bd_in.count != 3'd0);
         end
         if (in_valid && in_ready) begin
            phase_ff <= phase_in; idx_ff <= idx_in; acc_ff <= acc_in;
            ns_ff <= ns_in; keys_ff <= keys_in; chars_ff <= chars_in;
            wide_ff <= wide_in; low_ff <= low_in; stop_ff <= stop_in;
            nuls_ff <= nuls_in; any_ff <= any_in; role_ff <= role_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         bd_ff <= bd_in;
      end
   end

endmodule

>>> rtl/lsp_queue.sv
// Two-entry queue of result batches between the front end and the output stage.
module lsp_queue
   import lsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  batch_type wr_data,
   output logic      rd_valid,
   input  logic      rd_ready,
   output batch_type rd_data
);

   batch_type mem_ff [QueueDepth];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic      push, pop;

   assign wr_ready = (cnt_ff != 2'(QueueDepth));
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop  = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/lsp_back.sv
// Back end: sends the results of one batch one transfer at a time.
module lsp_back
   import lsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       b_valid,
   output logic       b_ready,
   input  batch_type  b_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic [2:0] sel_ff;
   logic       fin;

   assign out_valid = b_valid;
   assign out_data  = b_data.res[sel_ff];
   assign fin       = (sel_ff + 3'd1 >= b_data.count);
   assign b_ready   = out_valid && out_ready && fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (out_valid && out_ready) begin
         sel_ff <= fin ? 3'd0 : sel_ff + 3'd1;
      end
   end

endmodule
